// ----- rtl/rtbs_pkg.sv -----
// shared types and constants for the record table with bubble sort
`timescale 1ns / 1ps

package rtbs_pkg;

	// table size and derived widths
	localparam int DEPTH = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 6;
	localparam int CMP_W = POS_W + 1;
	localparam int ID_W  = 6;
	localparam int TAG_W = 32;
	localparam int KEY_W = 32;
	localparam int CMD_W = 3;
	localparam int ST_W  = 2;

	// stream word layout
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 80;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 3'd0,
		CMD_UPDATE = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_SORT   = 3'd3,
		CMD_READ   = 3'd4
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// one table record
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] key;
	} rec_t;

	// what a cell loads at the next edge
	typedef enum logic [2:0] {
		CELL_HOLD  = 3'd0,
		CELL_LOAD  = 3'd1,
		CELL_UPD   = 3'd2,
		CELL_RIGHT = 3'd3,
		CELL_LEFT  = 3'd4,
		CELL_WRAP  = 3'd5
	} cell_ctl_t;

endpackage

// ----- rtl/rtbs_cell.sv -----
// one table cell: holds a record and trades it with its neighbors
`timescale 1ns / 1ps

module rtbs_cell (
	input  logic               clk,
	input  rtbs_pkg::cell_ctl_t ctl,
	input  rtbs_pkg::rec_t     new_rec,
	input  rtbs_pkg::rec_t     right_rec,
	input  rtbs_pkg::rec_t     left_rec,
	input  rtbs_pkg::rec_t     wrap_rec,
	output rtbs_pkg::rec_t     rec,
	output logic               gt_right
);

	rtbs_pkg::rec_t rec_q;

	// record register, selected source per control
	always_ff @(posedge clk) begin
		case (ctl)
			rtbs_pkg::CELL_LOAD:  rec_q <= new_rec;
			rtbs_pkg::CELL_UPD: begin
				rec_q.tag <= new_rec.tag;
				rec_q.key <= new_rec.key;
			end
			rtbs_pkg::CELL_RIGHT: rec_q <= right_rec;
			rtbs_pkg::CELL_LEFT:  rec_q <= left_rec;
			rtbs_pkg::CELL_WRAP:  rec_q <= wrap_rec;
			default:              rec_q <= rec_q;
		endcase
	end

	// strict compare against the right neighbor for the sort exchange
	assign gt_right = rec_q.key > right_rec.key;
	assign rec      = rec_q;

endmodule

// ----- rtl/record_table_with_bubble_sort_unit.sv -----
// top level: command decode, sort sequencing, readout and the cell chain
`timescale 1ns / 1ps

// Record table of up to 32 records (id, tag, key) held in a chain of cells.
// Commands arrive on the s_ channel, one word per command; results leave on
// the m_ channel, each result word carrying status in m_tuser and m_tlast
// high on the final word of a command.
// Add, update and delete act in the cycle the command is taken; their single
// result word passes through the response state and then the output register.
// Sort runs odd-even exchange phases across the chain, one phase per cycle,
// count phases in all; a closing step ends the sort, and the result word then
// passes through the response state and the output register.
// Readout rotates the chain one place per word: count record words then a
// final word with the count, one word per cycle when the receiver keeps up.
// One command is worked at a time; s_tready is high whenever the block is
// idle, even while the last result word still waits in the output register.
// A stalled receiver holds the output register and freezes readout and the
// result hand-off; nothing is dropped.
// Reset clears the count and the control; the record storage is not cleared
// and is only read below the count.

module record_table_with_bubble_sort_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// position [5:0], key_value [37:6], tag_value [69:38], zero pad
	input  logic [rtbs_pkg::S_DATA_W-1:0] s_tdata,
	// command [2:0]
	input  logic [rtbs_pkg::CMD_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// record_id [5:0], record_tag [37:6], record_key [69:38],
	// entry_count [75:70], zero pad
	output logic [rtbs_pkg::M_DATA_W-1:0] m_tdata,
	// status [1:0]
	output logic [rtbs_pkg::ST_W-1:0]     m_tuser,
	output logic                          m_tlast
);

	localparam int DEPTH = rtbs_pkg::DEPTH;
	localparam int CNT_W = rtbs_pkg::CNT_W;
	localparam int CMP_W = rtbs_pkg::CMP_W;
	localparam int ID_W  = rtbs_pkg::ID_W;
	localparam int TAG_W = rtbs_pkg::TAG_W;
	localparam int KEY_W = rtbs_pkg::KEY_W;
	localparam int POS_W = rtbs_pkg::POS_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SORT = 4'b0010,
		S_RESP = 4'b0100,
		S_READ = 4'b1000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     step_q;
	rtbs_pkg::status_t    st_q;

	logic                 out_valid_q;
	rtbs_pkg::status_t    out_st_q;
	rtbs_pkg::rec_t       out_rec_q;
	logic [CNT_W-1:0]     out_cnt_q;
	logic                 out_last_q;

	rtbs_pkg::rec_t       cell_rec [DEPTH];
	logic [DEPTH-1:0]     cell_gt;
	rtbs_pkg::cell_ctl_t  cell_ctl [DEPTH];
	// bit j + 1 marks an exchange between cells j and j + 1; both ends stay low
	logic [DEPTH:0]       swp;

	logic                 in_acc;
	logic                 slot_free;
	rtbs_pkg::cmd_t       cmd;
	logic [POS_W-1:0]     pos;
	logic [CMP_W-1:0]     pos_x;
	logic [CMP_W-1:0]     cnt_x;
	logic                 pos_bad;
	logic                 tbl_full;
	rtbs_pkg::rec_t       new_rec;

	// input word unpacking
	assign cmd         = rtbs_pkg::cmd_t'(s_tuser);
	assign pos         = s_tdata[POS_W-1:0];
	assign new_rec.id  = ID_W'({1'b0, count_q} + 1'b1);
	assign new_rec.key = s_tdata[POS_W +: KEY_W];
	assign new_rec.tag = s_tdata[POS_W + KEY_W +: TAG_W];

	assign s_tready  = state_q == S_IDLE;
	assign in_acc    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;

	assign pos_x    = CMP_W'(pos);
	assign cnt_x    = CMP_W'(count_q);
	assign pos_bad  = (pos == '0) || (pos_x > cnt_x);
	assign tbl_full = cnt_x >= CMP_W'(DEPTH);

	// exchange decisions for the current sort phase
	always_comb begin
		swp[0]     = 1'b0;
		swp[DEPTH] = 1'b0;
		for (int j = 0; j < DEPTH - 1; j++) begin
			swp[j + 1] = (state_q == S_SORT) && (step_q != count_q)
				&& (j[0] == step_q[0]) && (CMP_W'(j + 1) < cnt_x) && cell_gt[j];
		end
	end

	// per-cell control
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i] = rtbs_pkg::CELL_HOLD;
			if (in_acc) begin
				case (cmd)
					rtbs_pkg::CMD_ADD:
						if (!tbl_full && CMP_W'(i) == cnt_x)
							cell_ctl[i] = rtbs_pkg::CELL_LOAD;
					rtbs_pkg::CMD_UPDATE:
						if (!pos_bad && CMP_W'(i + 1) == pos_x)
							cell_ctl[i] = rtbs_pkg::CELL_UPD;
					rtbs_pkg::CMD_DELETE:
						if (!pos_bad && CMP_W'(i + 1) >= pos_x && CMP_W'(i + 1) < cnt_x)
							cell_ctl[i] = rtbs_pkg::CELL_RIGHT;
					default: ;
				endcase
			end else if (state_q == S_SORT) begin
				if (swp[i + 1])
					cell_ctl[i] = rtbs_pkg::CELL_RIGHT;
				else if (swp[i])
					cell_ctl[i] = rtbs_pkg::CELL_LEFT;
			end else if (state_q == S_READ && slot_free && step_q != count_q) begin
				// rotate the live part of the chain by one place
				if (CMP_W'(i + 1) < cnt_x)
					cell_ctl[i] = rtbs_pkg::CELL_RIGHT;
				else if (CMP_W'(i + 1) == cnt_x)
					cell_ctl[i] = rtbs_pkg::CELL_WRAP;
			end
		end
	end

	// cell chain
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		rtbs_pkg::rec_t right_rec;
		rtbs_pkg::rec_t left_rec;

		if (g < DEPTH - 1) begin : g_r
			assign right_rec = cell_rec[g + 1];
		end else begin : g_rz
			assign right_rec = '0;
		end
		if (g > 0) begin : g_l
			assign left_rec = cell_rec[g - 1];
		end else begin : g_lz
			assign left_rec = '0;
		end

		rtbs_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[g]),
			.new_rec   (new_rec),
			.right_rec (right_rec),
			.left_rec  (left_rec),
			.wrap_rec  (cell_rec[0]),
			.rec       (cell_rec[g]),
			.gt_right  (cell_gt[g])
		);
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			step_q  <= '0;
			st_q    <= rtbs_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						step_q  <= '0;
						st_q    <= rtbs_pkg::ST_OK;
						state_q <= S_RESP;
						case (cmd)
							rtbs_pkg::CMD_ADD: begin
								if (tbl_full)
									st_q <= rtbs_pkg::ST_FULL;
								else
									count_q <= count_q + 1'b1;
							end
							rtbs_pkg::CMD_UPDATE: begin
								if (pos_bad)
									st_q <= rtbs_pkg::ST_BADPOS;
							end
							rtbs_pkg::CMD_DELETE: begin
								if (pos_bad)
									st_q <= rtbs_pkg::ST_BADPOS;
								else
									count_q <= count_q - 1'b1;
							end
							rtbs_pkg::CMD_SORT: state_q <= S_SORT;
							rtbs_pkg::CMD_READ: state_q <= S_READ;
							default: ;
						endcase
					end
				end
				S_SORT: begin
					if (step_q == count_q)
						state_q <= S_RESP;
					else
						step_q <= step_q + 1'b1;
				end
				S_RESP: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				S_READ: begin
					if (slot_free) begin
						if (step_q == count_q)
							state_q <= S_IDLE;
						else
							step_q <= step_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= (state_q == S_RESP) || (state_q == S_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			out_cnt_q <= count_q;
			if (state_q == S_READ && step_q != count_q) begin
				out_st_q   <= rtbs_pkg::ST_OK;
				out_rec_q  <= cell_rec[0];
				out_last_q <= 1'b0;
			end else begin
				out_st_q   <= (state_q == S_READ) ? rtbs_pkg::ST_OK : st_q;
				out_rec_q  <= '0;
				out_last_q <= 1'b1;
			end
		end
	end

	// output word packing
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {
		(rtbs_pkg::M_DATA_W - ID_W - TAG_W - KEY_W - ID_W)'(0),
		ID_W'(out_cnt_q),
		out_rec_q.key,
		out_rec_q.tag,
		out_rec_q.id
	};

endmodule

// ----- bench/record_table_with_bubble_sort_unit_test.sv -----
// testbench for the record table: random and directed commands checked against a predictor
`timescale 1ns / 1ps

module record_table_with_bubble_sort_unit_test;

	localparam int DEPTH    = rtbs_pkg::DEPTH;
	localparam int CNT_W    = rtbs_pkg::CNT_W;
	localparam int POS_W    = rtbs_pkg::POS_W;
	localparam int ID_W     = rtbs_pkg::ID_W;
	localparam int TAG_W    = rtbs_pkg::TAG_W;
	localparam int KEY_W    = rtbs_pkg::KEY_W;
	localparam int CMD_W    = rtbs_pkg::CMD_W;
	localparam int ST_W     = rtbs_pkg::ST_W;
	localparam int S_DATA_W = rtbs_pkg::S_DATA_W;
	localparam int M_DATA_W = rtbs_pkg::M_DATA_W;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO = rtbs_pkg::CMD_READ + 3'd1;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;
	localparam int QUIET_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_ITEMS  = 330;

	// one result word as the block should present it
	typedef struct {
		rtbs_pkg::status_t  status;
		logic [ID_W-1:0]    id;
		logic [TAG_W-1:0]   tag;
		logic [KEY_W-1:0]   key;
		logic [CNT_W-1:0]   count;
		logic               last;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [CMD_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [ST_W-1:0] m_tuser;
	logic m_tlast;

	// predicted table contents and pending results
	rtbs_pkg::rec_t roster [DEPTH];
	int roster_len = 0;
	result_word_t awaited_words [$];
	result_word_t head;

	int mismatch_total = 0;
	int quiet_cycles = 0;
	bit tx_pause_on = 1'b1;
	bit rx_pause_on = 1'b1;
	int rx_wait = 0;
	int rx_hold_left = 0;

	record_table_with_bubble_sort_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_pause(bit on);
		return on ? $urandom_range(0, 10) : 0;
	endfunction

	// keys lean toward a few small values so sorting sees plenty of ties
	function automatic logic [KEY_W-1:0] rand_key();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// mostly a live position, otherwise zero or something past the end
	function automatic logic [POS_W-1:0] rand_edit_pos();
		if (roster_len > 0 && $urandom_range(0, 99) < 85)
			return POS_W'($urandom_range(1, roster_len));
		if ($urandom_range(0, 2) == 0)
			return '0;
		return POS_W'($urandom_range(roster_len + 1, (1 << POS_W) - 1));
	endfunction

	function automatic void push_word(rtbs_pkg::status_t st, rtbs_pkg::rec_t r, logic last);
		result_word_t w;
		w.status = st;
		w.id     = r.id;
		w.tag    = r.tag;
		w.key    = r.key;
		w.count  = CNT_W'(roster_len);
		w.last   = last;
		awaited_words.push_back(w);
	endfunction

	// advance the predicted table by one command and queue its results
	function automatic void apply_table_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
			logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
		rtbs_pkg::status_t st;
		rtbs_pkg::rec_t tmp;
		st = rtbs_pkg::ST_OK;
		case (cmd)
			rtbs_pkg::CMD_ADD: begin
				if (roster_len >= DEPTH) begin
					st = rtbs_pkg::ST_FULL;
				end else begin
					roster[roster_len].id  = ID_W'(roster_len + 1);
					roster[roster_len].tag = tag;
					roster[roster_len].key = key;
					roster_len++;
				end
			end
			rtbs_pkg::CMD_UPDATE: begin
				if (pos == 0 || pos > roster_len) begin
					st = rtbs_pkg::ST_BADPOS;
				end else begin
					roster[pos - 1].tag = tag;
					roster[pos - 1].key = key;
				end
			end
			rtbs_pkg::CMD_DELETE: begin
				if (pos == 0 || pos > roster_len) begin
					st = rtbs_pkg::ST_BADPOS;
				end else begin
					for (int i = pos - 1; i + 1 < roster_len; i++)
						roster[i] = roster[i + 1];
					roster_len--;
				end
			end
			rtbs_pkg::CMD_SORT: begin
				// full bubble sort, swap only on strictly greater left key
				for (int sweep = 0; sweep < roster_len; sweep++)
					for (int j = 0; j + 1 < roster_len; j++)
						if (roster[j].key > roster[j + 1].key) begin
							tmp = roster[j];
							roster[j] = roster[j + 1];
							roster[j + 1] = tmp;
						end
			end
			rtbs_pkg::CMD_READ: begin
				for (int i = 0; i < roster_len; i++)
					push_word(rtbs_pkg::ST_OK, roster[i], 1'b0);
			end
			default: ;
		endcase
		push_word(st, '0, 1'b1);
	endfunction

	// offer one command word and wait until the block takes it
	task automatic send_word(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
			logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
		int gap;
		gap = pick_pause(tx_pause_on);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(S_DATA_W - POS_W - KEY_W - TAG_W){1'b0}}, tag, key, pos};
		do @(posedge clk); while (!s_tready);
		apply_table_command(cmd, pos, key, tag);
	endtask

	// empty table: nothing to sort, read, edit or delete; also the spare command codes
	task automatic test_empty_table();
		send_word(rtbs_pkg::CMD_READ, '0, '0, '0);
		send_word(rtbs_pkg::CMD_SORT, '0, '0, '0);
		send_word(rtbs_pkg::CMD_UPDATE, 6'd1, $urandom, $urandom);
		send_word(rtbs_pkg::CMD_DELETE, '0, '0, '0);
		send_word(CMD_SPARE_LO, '1, '1, '1);
		send_word(CMD_SPARE_LO + 3'd1, 6'd1, $urandom, $urandom);
		send_word(CMD_SPARE_HI, 6'd1, $urandom, $urandom);
	endtask

	// each command on a small table, with field extremes and bad positions
	task automatic test_basic_commands();
		send_word(rtbs_pkg::CMD_ADD, '0, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(rtbs_pkg::CMD_ADD, '0, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(rtbs_pkg::CMD_ADD, '1, 32'h8000_0000, 32'h5A5A_A5A5);
		send_word(rtbs_pkg::CMD_ADD, '0, 32'h0000_0001, 32'hA5A5_5A5A);
		send_word(rtbs_pkg::CMD_UPDATE, '0, $urandom, $urandom);
		send_word(rtbs_pkg::CMD_UPDATE, 6'd5, $urandom, $urandom);
		send_word(rtbs_pkg::CMD_UPDATE, '1, $urandom, $urandom);
		send_word(rtbs_pkg::CMD_UPDATE, 6'd4, 32'h7FFF_FFFF, 32'h1234_5678);
		send_word(rtbs_pkg::CMD_DELETE, 6'd32, '0, '0);
		send_word(rtbs_pkg::CMD_READ, '0, '0, '0);
		send_word(rtbs_pkg::CMD_SORT, '0, '0, '0);
		send_word(rtbs_pkg::CMD_READ, '0, '0, '0);
		send_word(rtbs_pkg::CMD_DELETE, 6'd1, '0, '0);
		send_word(rtbs_pkg::CMD_DELETE, 6'd3, '0, '0);
		send_word(rtbs_pkg::CMD_READ, '0, '0, '0);
		send_word(rtbs_pkg::CMD_DELETE, 6'd1, '0, '0);
		send_word(rtbs_pkg::CMD_DELETE, 6'd1, '0, '0);
		send_word(rtbs_pkg::CMD_READ, '0, '0, '0);
	endtask

	// fill to capacity, overflow, then edit, sort and read the full table
	task automatic test_full_table();
		while (roster_len < DEPTH)
			send_word(rtbs_pkg::CMD_ADD, POS_W'($urandom), rand_key(), $urandom);
		send_word(rtbs_pkg::CMD_ADD, '0, $urandom, $urandom);
		send_word(rtbs_pkg::CMD_ADD, '1, $urandom, $urandom);
		send_word(rtbs_pkg::CMD_UPDATE, POS_W'(DEPTH), rand_key(), $urandom);
		send_word(rtbs_pkg::CMD_UPDATE, POS_W'(DEPTH + 1), rand_key(), $urandom);
		send_word(rtbs_pkg::CMD_READ, '0, '0, '0);
		send_word(rtbs_pkg::CMD_SORT, '0, '0, '0);
		send_word(rtbs_pkg::CMD_READ, '0, '0, '0);
		send_word(rtbs_pkg::CMD_DELETE, POS_W'(DEPTH / 2), '0, '0);
		send_word(rtbs_pkg::CMD_ADD, '0, rand_key(), $urandom);
		send_word(rtbs_pkg::CMD_DELETE, POS_W'(DEPTH), '0, '0);
		send_word(rtbs_pkg::CMD_DELETE, 6'd1, '0, '0);
		send_word(rtbs_pkg::CMD_SORT, '0, '0, '0);
		send_word(rtbs_pkg::CMD_READ, '0, '0, '0);
	endtask

	// receiver stops for a long stretch while commands keep coming
	task automatic test_receiver_stall();
		tx_pause_on = 1'b0;
		rx_hold_left = LONG_HOLD;
		send_word(rtbs_pkg::CMD_READ, '0, '0, '0);
		repeat (16) begin
			case ($urandom_range(0, 3))
				0: send_word(rtbs_pkg::CMD_ADD, '0, rand_key(), $urandom);
				1: send_word(rtbs_pkg::CMD_UPDATE, rand_edit_pos(), rand_key(), $urandom);
				2: send_word(rtbs_pkg::CMD_SORT, '0, '0, '0);
				default: send_word(rtbs_pkg::CMD_DELETE, rand_edit_pos(), '0, '0);
			endcase
		end
		send_word(rtbs_pkg::CMD_READ, '0, '0, '0);
		tx_pause_on = 1'b1;
	endtask

	// mixed traffic; adds thin out once the table is half full
	task automatic test_random_traffic();
		int pick;
		int add_share;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				tx_pause_on = ($urandom_range(0, 9) < 7);
				rx_pause_on = ($urandom_range(0, 9) < 7);
			end
			add_share = (roster_len < DEPTH / 2) ? 45 : 22;
			pick = $urandom_range(0, 99);
			if (pick < add_share)
				send_word(rtbs_pkg::CMD_ADD, POS_W'($urandom), rand_key(), $urandom);
			else if (pick < add_share + 20)
				send_word(rtbs_pkg::CMD_UPDATE, rand_edit_pos(), rand_key(), $urandom);
			else if (pick < add_share + 40)
				send_word(rtbs_pkg::CMD_DELETE, rand_edit_pos(), $urandom, $urandom);
			else if (pick < add_share + 47)
				send_word(rtbs_pkg::CMD_SORT, POS_W'($urandom), $urandom, $urandom);
			else if (pick < add_share + 55)
				send_word(rtbs_pkg::CMD_READ, POS_W'($urandom), $urandom, $urandom);
			else
				send_word(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
					POS_W'($urandom), $urandom, $urandom);
		end
	endtask

	task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_total++;
		end
	endtask

	// receiver: per-word pause plus an optional long hold
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_tready <= 1'b0;
				rx_hold_left--;
			end else if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each delivered word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			rx_wait = pick_pause(rx_pause_on);
			if (awaited_words.size() == 0) begin
				$error("result word with nothing expected: tdata %0h tuser %0d",
					m_tdata, m_tuser);
				mismatch_total++;
			end else begin
				head = awaited_words.pop_front();
				check_field("status", KEY_W'(head.status), KEY_W'(m_tuser));
				check_field("record_id", KEY_W'(head.id), KEY_W'(m_tdata[5:0]));
				check_field("record_tag", head.tag, m_tdata[37:6]);
				check_field("record_key", head.key, m_tdata[69:38]);
				check_field("entry_count", KEY_W'(head.count), KEY_W'(m_tdata[75:70]));
				check_field("last", KEY_W'(head.last), KEY_W'(m_tlast));
			end
		end
	end

	// watchdog on cycles where neither side moves a word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = rtbs_pkg::CMD_ADD;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_basic_commands();
		test_full_table();
		test_receiver_stall();
		test_random_traffic();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (awaited_words.size() != 0) begin
			$error("%0d result words never arrived", awaited_words.size());
			mismatch_total++;
		end
		if (mismatch_total == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/rtbs_pkg.sv
rtl/rtbs_cell.sv
rtl/record_table_with_bubble_sort_unit.sv
bench/record_table_with_bubble_sort_unit_test.sv
